/* rtl/fip_pkg.sv */
// Shared types and constants for the FIFO with indexed peek.
// Used by the channel interfaces, the controller, the datapath and the top level.
package fip_pkg;

    // Widths of the channel fields.
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 6;
    localparam int DATA_OUT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 6;

    // Default sizing of the queue.
    localparam int DEFAULT_DEPTH      = 32;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // Command codes; the remaining code is a no-op.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a request beat is taken at this edge
        logic out_load;  // the result register loads at this edge
    } ctrl_t;

endpackage

/* rtl/fip_req_if.sv */
// Request channel: one command beat with its operands.
// Depends on fip_pkg for the field widths.
interface fip_req_if;
    logic                              valid;
    logic                              ready;
    logic [fip_pkg::CMD_W-1:0]         command;
    logic signed [fip_pkg::VALUE_W-1:0] value;
    logic [fip_pkg::POS_W-1:0]         position;
    logic                              from_rear;
    logic                              discard_ahead;

    modport source (output valid, command, value, position, from_rear, discard_ahead,
                    input ready);
    modport sink (input valid, command, value, position, from_rear, discard_ahead,
                  output ready);
endinterface

/* rtl/fip_rsp_if.sv */
// Response channel: one result beat per command.
// Depends on fip_pkg for the field widths.
interface fip_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fip_pkg::DATA_OUT_W-1:0] data;
    logic [fip_pkg::STATUS_W-1:0]          status;
    logic [fip_pkg::OCC_W-1:0]             occupancy;

    modport source (output valid, data, status, occupancy, input ready);
    modport sink (input valid, data, status, occupancy, output ready);
endinterface

/* rtl/fip_ctrl.sv */
// Controller of the FIFO with indexed peek: handshake and sequencing.
// Depends on fip_pkg for the state and command types.
module fip_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output fip_pkg::ctrl_t  ctrl
);
    import fip_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_load;
    logic   accept;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands. A command in flight moves to the result
    // register once that register is free or being drained; a new beat is
    // taken in the same cycle.
    always_comb
    begin
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: out_load = 1'b0;
            ST_EXEC: out_load = !out_valid_reg || out_ready;
            default: out_load = 1'b0;
        endcase

        in_ready = (state_reg == ST_IDLE) || out_load;
        accept   = in_valid && in_ready;

        state_next = state_reg;
        priority if (accept)
        begin
            state_next = ST_EXEC;
        end
        else if (out_load)
        begin
            state_next = ST_IDLE;
        end

        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        ctrl.accept   = accept;
        ctrl.out_load = out_load;
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/fip_datapath.sv */
// Datapath of the FIFO with indexed peek: ring buffer, pointers and result register.
// Depends on fip_pkg for codes, widths and the control struct.
module fip_datapath #(
    parameter int DEPTH      = fip_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = fip_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  fip_pkg::ctrl_t                         ctrl,
    input  logic [fip_pkg::CMD_W-1:0]              command,
    input  logic signed [fip_pkg::VALUE_W-1:0]     value,
    input  logic [fip_pkg::POS_W-1:0]              position,
    input  logic                                   from_rear,
    input  logic                                   discard_ahead,
    output logic signed [fip_pkg::DATA_OUT_W-1:0]  data,
    output logic [fip_pkg::STATUS_W-1:0]           status,
    output logic [fip_pkg::OCC_W-1:0]              occupancy
);
    import fip_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Ring storage and its registered read port.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [AW-1:0] front_reg;
    logic [AW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Result of the command in flight, waiting for the read data.
    status_t        pend_status_reg;
    logic [CW-1:0]  pend_occ_reg;
    logic           pend_use_reg;

    logic signed [DATA_OUT_W-1:0] out_data_reg;
    status_t                      out_status_reg;
    logic [OCC_W-1:0]             out_occ_reg;

    cmd_t                  cmd;
    status_t               stat;
    logic                  use_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic [CMPW-1:0]       ahead_w;
    logic [AW-1:0]         ahead;
    logic                  in_range;
    logic                  full;
    logic                  empty;
    logic [AW-1:0]         slot;
    logic [AW-1:0]         tail;
    logic [AW-1:0]         front_inc;
    logic [DATA_OUT_W-1:0] rd_word;

    // Modular add of two ring indices, each below DEPTH.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Address arithmetic for push, pop and peek.
    always_comb
    begin
        cmd       = cmd_t'(command);
        pos_ext   = CMPW'(position);
        cnt_ext   = CMPW'(count_reg);
        full      = (count_reg == CW'(DEPTH));
        empty     = (count_reg == '0);
        in_range  = (pos_ext != '0) && (pos_ext <= cnt_ext);
        ahead_w   = from_rear ? (cnt_ext - pos_ext) : (pos_ext - CMPW'(1));
        ahead     = ahead_w[AW-1:0];
        slot      = ring_add(front_reg, ahead);
        tail      = ring_add(front_reg, count_reg[AW-1:0]);
        front_inc = ring_add(front_reg, AW'(1));
        wr_data   = DATA_WIDTH'($unsigned(value));
    end

    // Command decode: next pointers, memory access and result status.
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        stat       = STAT_OK;
        use_data   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = tail;
        rd_addr    = front_reg;
        unique case (cmd)
            CMD_PUSH:
            begin
                if (full)
                begin
                    stat = STAT_FULL;
                end
                else
                begin
                    wr_en      = ctrl.accept;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP:
            begin
                if (empty)
                begin
                    stat = STAT_EMPTY;
                end
                else
                begin
                    use_data   = 1'b1;
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_PEEK:
            begin
                rd_addr = slot;
                if (!in_range)
                begin
                    stat = STAT_RANGE;
                end
                else
                begin
                    use_data = 1'b1;
                    if (discard_ahead)
                    begin
                        front_next = slot;
                        count_next = count_reg - CW'(ahead);
                    end
                end
            end
            default:
            begin
                stat = STAT_OK;
            end
        endcase
    end

    // Ring storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Pending result of the accepted beat and the output register.
    assign rd_word = DATA_OUT_W'(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            pend_status_reg <= stat;
            pend_occ_reg    <= count_next;
            pend_use_reg    <= use_data;
        end
        if (ctrl.out_load)
        begin
            out_data_reg   <= pend_use_reg ? signed'(rd_word) : '0;
            out_status_reg <= pend_status_reg;
            out_occ_reg    <= OCC_W'(pend_occ_reg);
        end
    end

    assign data      = out_data_reg;
    assign status    = out_status_reg;
    assign occupancy = out_occ_reg;

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    // The front index stays inside the ring.
    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg < AW'(DEPTH) || DEPTH == (1 << AW))
        else $error("front index outside ring");

    // A push on a full queue leaves the count alone.
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept && cmd == CMD_PUSH && full |=> $stable(count_reg))
        else $error("push on full changed the count");

    // A pop on a non-empty queue removes exactly one element.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept && cmd == CMD_POP && !empty |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not remove one element");

endmodule

/* rtl/fifo_with_indexed_peek.sv */
// FIFO of signed words with indexed peek (push, pop, peek with optional discard).
// A taken request beat passes through the registered memory read port and the pending
// result registers, then the output register, before its result beat is valid. Throughput:
// one command per cycle while results drain; while a result beat stalls one more command
// waits in the datapath and the request side stalls.
// Reset (rst_n, asynchronous, active low) empties the queue; stored words are not cleared.
module fifo_with_indexed_peek #(
    parameter int DEPTH      = fip_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = fip_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic    clk,
    input  logic    rst_n,
    fip_req_if.sink req,
    fip_rsp_if.source rsp
);
    import fip_pkg::*;

    ctrl_t ctrl;

    // Handshake and sequencing.
    fip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    // Ring buffer, pointers and result register.
    fip_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .command       (req.command),
        .value         (req.value),
        .position      (req.position),
        .from_rear     (req.from_rear),
        .discard_ahead (req.discard_ahead),
        .data          (rsp.data),
        .status        (rsp.status),
        .occupancy     (rsp.occupancy)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for fifo_with_indexed_peek: push, pop and indexed peek with discard.
// Every result beat is checked against a queue model in the testbench.
// Depends on fip_pkg, fip_req_if, fip_rsp_if and the RTL top level.
module testbench;
    import fip_pkg::*;

    localparam int QDEPTH       = DEFAULT_DEPTH;
    localparam int QAW          = $clog2(QDEPTH);
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int IDLE_PCT     = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 40;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic signed [DATA_OUT_W-1:0] data;
        status_t                      status;
        logic [OCC_W-1:0]             occupancy;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fip_req_if req_ch();
    fip_rsp_if rsp_ch();

    // Queue model: ring of words addressed by a front index and an element count.
    logic signed [VALUE_W-1:0] model_words [QDEPTH];
    int unsigned model_front;
    int unsigned model_count;

    // Outcomes predicted for accepted commands, oldest first.
    outcome_t pending_results [$];

    bit calm_mode;
    int stall_request;
    int hold_left;
    int cycle_count;
    int fail_count;
    int results_checked;
    int sent_push, sent_pop, sent_peek, sent_nop;
    int full_hits, empty_hits, range_hits, discard_hits;

    fifo_with_indexed_peek i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the queue model and return the outcome it should produce.
    function automatic outcome_t queue_model_step(input logic [CMD_W-1:0] cmd,
                                                  input logic signed [VALUE_W-1:0] val,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic rear,
                                                  input logic drop);
        outcome_t    res;
        int unsigned ahead;
        int unsigned slot;
        int unsigned p;
        res.data   = '0;
        res.status = STAT_OK;
        p          = 32'(pos);
        case (cmd)
            CMD_PUSH:
            begin
                if (model_count >= QDEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    model_words[QAW'((model_front + model_count) % QDEPTH)] = val;
                    model_count++;
                end
            end
            CMD_POP:
            begin
                if (model_count == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.data    = model_words[QAW'(model_front)];
                    model_front = (model_front + 1) % QDEPTH;
                    model_count--;
                end
            end
            CMD_PEEK:
            begin
                if (p == 0 || p > model_count)
                    res.status = STAT_RANGE;
                else
                begin
                    // Distance of the target from the front.
                    ahead    = rear ? (model_count - p) : (p - 1);
                    slot     = (model_front + ahead) % QDEPTH;
                    res.data = model_words[QAW'(slot)];
                    if (drop)
                    begin
                        model_front = slot;
                        model_count = model_count - ahead;
                    end
                end
            end
            default:
            begin
                // The unused code leaves everything as it is.
            end
        endcase
        res.occupancy = model_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Offer one command beat, with random idle cycles ahead of it unless calm.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos,
                                input logic rear,
                                input logic drop);
        outcome_t res;
        if (!calm_mode)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid         <= 1'b1;
        req_ch.command       <= cmd;
        req_ch.value         <= val;
        req_ch.position      <= pos;
        req_ch.from_rear     <= rear;
        req_ch.discard_ahead <= drop;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);

        // The beat was taken at this edge.
        res = queue_model_step(cmd, val, pos, rear, drop);
        pending_results.push_back(res);
        case (cmd)
            CMD_PUSH: sent_push++;
            CMD_POP:  sent_pop++;
            CMD_PEEK: sent_peek++;
            default:  sent_nop++;
        endcase
        case (res.status)
            STAT_FULL:  full_hits++;
            STAT_EMPTY: empty_hits++;
            STAT_RANGE: range_hits++;
            default:
            begin
                if (cmd == CMD_PEEK && drop)
                    discard_hits++;
            end
        endcase
    endtask

    // A random word, with the extremes mixed in now and then.
    function automatic logic signed [VALUE_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // Corners: empty queue, extreme words, every peek direction and out-of-range position.
    task automatic test_directed_corners();
        send_command(CMD_POP,  32'sd0, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'sd0, 6'd1, 1'b0, 1'b0);
        send_command(CMD_NOP,  32'sd0, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PUSH, 32'sh7fff_ffff, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PUSH, 32'sh8000_0000, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PUSH, 32'sd0, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PUSH, -32'sd1, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PUSH, 32'sh5a5a_a5a5, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'sd0, 6'd0, 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'sd0, 6'd6, 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'sd0, 6'd63, 1'b1, 1'b1);
        send_command(CMD_PEEK, 32'sd0, 6'd1, 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'sd0, 6'd1, 1'b1, 1'b0);
        send_command(CMD_PEEK, 32'sd0, 6'd5, 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'sd0, 6'd2, 1'b1, 1'b0);
        // Discard from the front side, then a rear peek that drops nothing, then one that does.
        send_command(CMD_PEEK, 32'sd0, 6'd3, 1'b0, 1'b1);
        send_command(CMD_PEEK, 32'sd0, 6'd3, 1'b1, 1'b1);
        send_command(CMD_PEEK, 32'sd0, 6'd1, 1'b1, 1'b1);
        send_command(CMD_NOP,  32'sh7fff_ffff, 6'd63, 1'b1, 1'b1);
        send_command(CMD_POP,  32'sd0, 6'd0, 1'b0, 1'b0);
        send_command(CMD_POP,  32'sd0, 6'd0, 1'b0, 1'b0);
    endtask

    // Fill to full after a response-side hold, push and peek on the full queue, then drain to empty.
    task automatic test_fill_and_drain();
        int n_push;
        n_push    = QDEPTH - model_count;
        calm_mode = 1'b1;
        stall_request = HOLD_CYCLES;
        for (int i = 0; i < n_push; i++)
            send_command(CMD_PUSH, random_word(), 6'($urandom()), 1'($urandom()),
                         1'($urandom()));
        send_command(CMD_PUSH, random_word(), 6'd0, 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'($urandom()), 6'(QDEPTH), 1'b0, 1'b0);
        send_command(CMD_PEEK, 32'($urandom()), 6'(QDEPTH), 1'b1, 1'b0);
        send_command(CMD_PEEK, 32'($urandom()), 6'(QDEPTH + 1), 1'b0, 1'b0);
        calm_mode = 1'b0;
        for (int i = 0; i <= QDEPTH; i++)
            send_command(CMD_POP, 32'($urandom()), 6'($urandom()), 1'($urandom()),
                         1'($urandom()));
    endtask

    // Random mix of commands; peek positions mostly in range, sometimes anywhere.
    task automatic test_random_mix(input int n_items);
        int               roll;
        int               push_limit;
        logic [POS_W-1:0] pos;
        for (int i = 0; i < n_items; i++)
        begin
            roll       = $urandom_range(99);
            push_limit = (model_count > 24) ? 30 : 50;
            if (model_count > 0 && $urandom_range(99) < 85)
                pos = POS_W'($urandom_range(model_count, 1));
            else
                pos = POS_W'($urandom());
            if (roll < 5)
                send_command(CMD_NOP, 32'($urandom()), 6'($urandom()), 1'($urandom()),
                             1'($urandom()));
            else if (roll < push_limit)
                send_command(CMD_PUSH, random_word(), 6'($urandom()), 1'($urandom()),
                             1'($urandom()));
            else if (roll < push_limit + 18)
                send_command(CMD_POP, 32'($urandom()), 6'($urandom()), 1'($urandom()),
                             1'($urandom()));
            else
                send_command(CMD_PEEK, 32'($urandom()), pos, 1'($urandom()),
                             ($urandom_range(99) < 25));
        end
    endtask

    // Response side: long hold when asked, otherwise ready with random stalls.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && stall_request > 0)
            begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (calm_mode)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending: data %0d",
                                          rsp_ch.data));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (rsp_ch.data !== want.data)
                    report_mismatch($sformatf("data %0d, predicted %0d",
                                              rsp_ch.data, want.data));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %s",
                                              rsp_ch.status, want.status.name()));
                if (rsp_ch.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                              rsp_ch.occupancy, want.occupancy));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        req_ch.valid         <= 1'b0;
        req_ch.command       <= CMD_PUSH;
        req_ch.value         <= '0;
        req_ch.position      <= '0;
        req_ch.from_rear     <= 1'b0;
        req_ch.discard_ahead <= 1'b0;
        model_front = 0;
        model_count = 0;
        calm_mode   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_fill_and_drain();
        calm_mode = 1'b0;
        test_random_mix(130);
        calm_mode = 1'b1;
        test_random_mix(100);
        calm_mode = 1'b0;
        test_random_mix(130);

        // Let the last results drain, then watch for stray beats.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d push, %0d pop, %0d peek, %0d unused-code beats; %0d results checked",
                 sent_push, sent_pop, sent_peek, sent_nop, results_checked);
        $display("Push on full %0d, pop on empty %0d, out of range %0d, discarding peeks %0d",
                 full_hits, empty_hits, range_hits, discard_hits);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/fip_pkg.sv
rtl/fip_req_if.sv
rtl/fip_rsp_if.sv
rtl/fip_ctrl.sv
rtl/fip_datapath.sv
rtl/fifo_with_indexed_peek.sv
test/testbench.sv
